[sv/vac_pkg.sv]
package vac_pkg;

   localparam int unsigned CHAR_W    = 8;
   localparam int unsigned SHIFT_W   = 5;
   localparam int unsigned KEY_POS_W = 4;
   localparam int unsigned KEY_LEN_W = 5;
   localparam int unsigned KEY_W     = 128;
   localparam int unsigned CSR_W     = 64;

   localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7a;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5a;
   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;

   localparam logic [SHIFT_W-1:0] ALPHA_MOD = 5'd26;
   localparam logic [SHIFT_W-1:0] DIGIT_MOD = 5'd10;

   typedef enum logic [1:0] {
      CSR_DIRECTION,
      CSR_KEY_LENGTH,
      CSR_KEY_LOW,
      CSR_KEY_HIGH
   } csr_index_type;

   typedef enum logic [1:0] {
      CLS_LOWER,
      CLS_UPPER,
      CLS_DIGIT,
      CLS_OTHER
   } char_class_type;

   typedef struct packed {
      logic                 direction;
      logic [KEY_LEN_W-1:0] key_length;
      logic [KEY_W-1:0]     key_bytes;
   } vac_cfg_type;

   // one classified request between front and back
   typedef struct packed {
      logic [CHAR_W-1:0]  char_byte;
      char_class_type     cls;
      logic [SHIFT_W-1:0] shift;
   } vac_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } vac_fifo_status_type;

   // (b - 'a') mod 26 taken non-negative, as (b + 7) mod 26 via reciprocal
   function automatic logic [SHIFT_W-1:0] key_shift_f(input logic [CHAR_W-1:0] b);
      logic [8:0]  x;
      logic [15:0] prod;
      logic [4:0]  q;
      logic [8:0]  r;
      x    = {1'b0, b} + 9'd7;
      prod = 16'(x) * 16'd79;
      q    = prod[15:11];
      r    = x - 9'(q) * 9'd26;
      return r[SHIFT_W-1:0];
   endfunction

   // shift in 0..25 reduced mod 10
   function automatic logic [SHIFT_W-1:0] digit_shift_f(input logic [SHIFT_W-1:0] s);
      logic [SHIFT_W-1:0] r;
      if (s >= 5'd20) begin
         r = s - 5'd20;
      end else if (s >= 5'd10) begin
         r = s - 5'd10;
      end else begin
         r = s;
      end
      return r;
   endfunction

endpackage

[sv/vac_fifo.sv]
module vac_fifo
   import vac_pkg::*;
#(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  logic [WIDTH-1:0]    wr_data,
   input  logic                rd_en,
   output logic [WIDTH-1:0]    rd_data,
   output vac_fifo_status_type status
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign status.full  = (count_ff == FULL_CNT);
   assign status.empty = (count_ff == '0);
   assign do_wr   = wr_en && !status.full;
   assign do_rd   = rd_en && !status.empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

[sv/vac_front.sv]
module vac_front
   import vac_pkg::*;
#(
   parameter int unsigned KEY_MAX = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [CHAR_W-1:0] char_in,
   input  logic              message_start,
   input  vac_cfg_type       cfg,
   output vac_item_type      item
);

   localparam logic [KEY_LEN_W-1:0] KEY_MAX_LEN = KEY_LEN_W'(KEY_MAX);

   logic [KEY_POS_W-1:0] pos_ff, pos_in;
   logic [KEY_POS_W-1:0] start_pos;
   logic [KEY_POS_W-1:0] pos;
   logic [KEY_LEN_W-1:0] len;
   logic [KEY_LEN_W-1:0] pos_next;
   logic [CHAR_W-1:0]    key_byte;
   logic [SHIFT_W-1:0]   shift;
   char_class_type       cls;

   // effective key length, 1..KEY_MAX
   always_comb begin
      priority if (cfg.key_length == '0) begin
         len = KEY_LEN_W'(1);
      end else if (cfg.key_length > KEY_MAX_LEN) begin
         len = KEY_MAX_LEN;
      end else begin
         len = cfg.key_length;
      end
   end

   always_comb begin
      start_pos = message_start ? '0 : pos_ff;
      pos       = ({1'b0, start_pos} >= len) ? '0 : start_pos;
      pos_next  = {1'b0, pos} + 1'b1;
      if (pos_next >= len) begin
         pos_next = '0;
      end
   end

   assign key_byte = cfg.key_bytes[{pos, 3'b000} +: CHAR_W];
   assign shift    = key_shift_f(key_byte);

   always_comb begin
      priority if (char_in >= CHAR_LOWER_A && char_in <= CHAR_LOWER_Z) begin
         cls = CLS_LOWER;
      end else if (char_in >= CHAR_UPPER_A && char_in <= CHAR_UPPER_Z) begin
         cls = CLS_UPPER;
      end else if (char_in >= CHAR_ZERO && char_in <= CHAR_NINE) begin
         cls = CLS_DIGIT;
      end else begin
         cls = CLS_OTHER;
      end
   end

   always_comb begin
      item.char_byte = char_in;
      item.cls       = cls;
      item.shift     = (cls == CLS_DIGIT) ? digit_shift_f(shift) : shift;
   end

   // only letters and digits move the key position
   assign pos_in = (cls == CLS_OTHER) ? start_pos : pos_next[KEY_POS_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (accept) begin
         pos_ff <= pos_in;
      end
   end

endmodule

[sv/vac_back.sv]
module vac_back
   import vac_pkg::*;
(
   input  logic              direction,
   input  vac_item_type      item,
   output logic [CHAR_W-1:0] char_out
);

   logic [CHAR_W-1:0]  base;
   logic [CHAR_W-1:0]  offset;
   logic [SHIFT_W-1:0] modulus;
   logic [SHIFT_W-1:0] v;
   logic [SHIFT_W:0]   sum;
   logic [SHIFT_W-1:0] t;

   always_comb begin
      unique case (item.cls)
         CLS_LOWER: begin
            base    = CHAR_LOWER_A;
            modulus = ALPHA_MOD;
         end
         CLS_UPPER: begin
            base    = CHAR_UPPER_A;
            modulus = ALPHA_MOD;
         end
         CLS_DIGIT: begin
            base    = CHAR_ZERO;
            modulus = DIGIT_MOD;
         end
         default: begin
            base    = '0;
            modulus = ALPHA_MOD;
         end
      endcase
   end

   always_comb begin
      offset = item.char_byte - base;
      v      = offset[SHIFT_W-1:0];
      sum    = {1'b0, v} + {1'b0, item.shift};
      if (direction) begin
         if (v >= item.shift) begin
            t = v - item.shift;
         end else begin
            t = v + modulus - item.shift;
         end
      end else begin
         if (sum >= {1'b0, modulus}) begin
            t = SHIFT_W'(sum - {1'b0, modulus});
         end else begin
            t = sum[SHIFT_W-1:0];
         end
      end
      char_out = (item.cls == CLS_OTHER) ? item.char_byte : base + CHAR_W'(t);
   end

endmodule

[sv/vigenere_alnum_cipher.sv]
// vigenere_alnum_cipher: byte-stream Vigenere cipher over letters and digits. Each request
// carries one text byte and a message_start flag; each returns exactly one byte, in order.
// Letters shift within their case mod 26 and digits mod 10 by the current key character's
// offset from 'a' ((byte - 'a') mod 26, non-negative); direction 0 adds, 1 subtracts.
// Other bytes pass through and do not advance the key position. message_start rewinds the
// position to zero before its byte. Throughput is one request per clock while full is low;
// a taken request passes through the classify queue and then the result queue, each two
// entries deep, before it can be popped on the rsp side; a full result queue stalls it.
// Configuration writes through the csr port take effect at once and belong only in idle
// periods; key_length 0 acts as 1 and values above KEY_MAX saturate.
module vigenere_alnum_cipher
   import vac_pkg::*;
#(
   parameter int unsigned KEY_MAX = 16
) (
   input  logic              clock,
   input  logic              reset,
   // request side
   input  logic              push,
   output logic              full,
   input  logic [CHAR_W-1:0] req_char_in,
   input  logic              req_message_start,
   // response side
   output logic              empty,
   input  logic              pop,
   output logic [CHAR_W-1:0] rsp_char_out,
   // register writes
   input  logic              csr_we,
   input  csr_index_type     csr_index,
   input  logic [CSR_W-1:0]  csr_data
);

   localparam int unsigned ITEM_W    = $bits(vac_item_type);
   localparam int unsigned Q_DEPTH   = 2;

   vac_cfg_type         cfg_ff;
   vac_item_type        front_item;
   vac_item_type        back_item;
   logic [ITEM_W-1:0]   mid_rd_data;
   vac_fifo_status_type mid_status;
   vac_fifo_status_type out_status;
   logic                req_accept;
   logic                move;
   logic [CHAR_W-1:0]   back_char;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.direction  <= 1'b0;
         cfg_ff.key_length <= KEY_LEN_W'(1);
         cfg_ff.key_bytes  <= {16{CHAR_LOWER_A}};
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DIRECTION:  cfg_ff.direction            <= csr_data[0];
            CSR_KEY_LENGTH: cfg_ff.key_length           <= csr_data[KEY_LEN_W-1:0];
            CSR_KEY_LOW:    cfg_ff.key_bytes[CSR_W-1:0] <= csr_data;
            CSR_KEY_HIGH:   cfg_ff.key_bytes[KEY_W-1:CSR_W] <= csr_data;
            default: ;
         endcase
      end
   end

   // front: classify the byte and look up its key shift as the request is taken
   assign full       = mid_status.full;
   assign req_accept = push && !mid_status.full;

   vac_front #(
      .KEY_MAX (KEY_MAX)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (req_accept),
      .char_in       (req_char_in),
      .message_start (req_message_start),
      .cfg           (cfg_ff),
      .item          (front_item)
   );

   // classified requests waiting for the back end
   vac_fifo #(
      .WIDTH (ITEM_W),
      .DEPTH (Q_DEPTH)
   ) u_mid_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (req_accept),
      .wr_data (front_item),
      .rd_en   (move),
      .rd_data (mid_rd_data),
      .status  (mid_status)
   );

   // back: modular add or subtract, one item per cycle while the result queue has room
   assign back_item = vac_item_type'(mid_rd_data);
   assign move      = !mid_status.empty && !out_status.full;

   vac_back u_back (
      .direction (cfg_ff.direction),
      .item      (back_item),
      .char_out  (back_char)
   );

   // finished bytes waiting to be popped
   vac_fifo #(
      .WIDTH (CHAR_W),
      .DEPTH (Q_DEPTH)
   ) u_out_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (move),
      .wr_data (back_char),
      .rd_en   (pop),
      .rd_data (rsp_char_out),
      .status  (out_status)
   );

   assign empty = out_status.empty;

   // nothing is left over from before reset
   assert property (@(posedge clock) reset |=> empty && !full)
      else $error("queues not cleared by reset");

   // a taken request is waiting in the classify queue on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      push && !full |=> !mid_status.empty)
      else $error("accepted request lost before the back end");

   // a byte moved by the back end is visible to the consumer on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      move |=> !empty)
      else $error("processed byte missing from the response queue");

endmodule
